// ----- hw/rtl/rwtc_pkg.sv -----
// Package for the raycast wall texture column unit.
// Holds the item and queue entry types, the configuration struct and shared constants.
// No dependencies.
`timescale 1ns / 1ps

package rwtc_pkg;

    localparam int SCREEN_COORD_BITS = 12;
    localparam int MAX_TEXTURE_LOG2  = 10;

    localparam logic [11:0] COORD_MASK = 12'((32'd1 << SCREEN_COORD_BITS) - 32'd1);

    // Dividend is (2^log2) << 16, so it needs MAX_TEXTURE_LOG2 + 17 bits.
    localparam int DIV_BITS     = MAX_TEXTURE_LOG2 + 17;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam logic OP_START = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [1:0] CFG_TEXTURE_WIDTH       = 2'd0;
    localparam logic [1:0] CFG_TEXTURE_HEIGHT_LOG2 = 2'd1;
    localparam logic [1:0] CFG_SCREEN_HEIGHT       = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [15:0] wall_fraction;
        logic [15:0] slice_height;
        logic [11:0] first_row;
        logic [12:0] end_row_in;
        logic [1:0]  wall_face;
        logic [11:0] screen_column;
    } t_in_item;

    typedef struct packed {
        logic [11:0] pixel_column;
        logic [11:0] pixel_row;
        logic [1:0]  texture_select;
        logic [9:0]  texel_x;
        logic [9:0]  texel_y;
        logic        last_row;
    } t_out_item;

    typedef struct packed {
        logic [10:0] texture_width;
        logic [3:0]  texture_height_log2;
        logic [11:0] screen_height;
    } t_cfg;

    typedef struct packed {
        logic        operation;
        logic [9:0]  texel_x;
        logic [15:0] slice_height;
        logic [11:0] first_row;
        logic [12:0] end_row_in;
        logic [1:0]  wall_face;
        logic [11:0] screen_column;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_MUL
    } t_back_state;

endpackage

// ----- hw/rtl/rwtc_front.sv -----
// Front stage: accepts input transactions, computes the mirrored texture column.
// Depends on rwtc_pkg; feeds rwtc_queue.
`timescale 1ns / 1ps

module rwtc_front import rwtc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  t_cfg     i_cfg,
    input  logic     i_q_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic        r_valid;
    t_cmd        r_cmd;
    t_cmd        n_cmd;
    logic [26:0] w_prod;
    logic [10:0] w_hit;

    assign o_in_ready = !r_valid || !i_q_full;
    assign o_push     = r_valid && !i_q_full;
    assign o_cmd      = r_cmd;

    always_comb begin
        w_prod = 27'(i_in_item.wall_fraction) * 27'(i_cfg.texture_width);
        w_hit  = w_prod[26:16];
        n_cmd.operation     = i_in_item.operation;
        n_cmd.texel_x       = 10'(i_cfg.texture_width - w_hit - 11'd1);
        n_cmd.slice_height  = i_in_item.slice_height;
        n_cmd.first_row     = i_in_item.first_row;
        n_cmd.end_row_in    = i_in_item.end_row_in;
        n_cmd.wall_face     = i_in_item.wall_face;
        n_cmd.screen_column = i_in_item.screen_column;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ----- hw/rtl/rwtc_queue.sv -----
// Short command queue between front and back.
// Depends on rwtc_pkg.
`timescale 1ns / 1ps

module rwtc_queue import rwtc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd                      r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_PTR_BITS:0]   r_count;

    assign o_full  = (r_count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("queue pop while empty");
`endif

endmodule

// ----- hw/rtl/rwtc_back.sv -----
// Back stage: column setup (iterative step division, start position) and pixel output.
// Depends on rwtc_pkg; reads commands from rwtc_queue.
`timescale 1ns / 1ps

module rwtc_back import rwtc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_back_state             r_state;
    t_back_state             n_state;
    logic [31:0]             r_step;
    logic [31:0]             r_pos;
    logic [12:0]             r_cur;
    logic [12:0]             r_stop;
    logic [11:0]             r_col;
    logic [1:0]              r_face;
    logic [9:0]              r_tx;
    logic [17:0]             r_diff;
    logic [15:0]             r_rem;
    logic [DIV_BITS-1:0]     r_quot;
    logic [15:0]             r_divisor;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic                    r_out_valid;
    t_out_item               r_out_item;

    logic [3:0]          w_lg;
    logic [15:0]         w_hmask;
    logic                w_out_free;
    logic                w_is_start;
    logic                w_start;
    logic                w_pixel;
    logic                w_emit;
    logic [16:0]         w_trial;
    logic [16:0]         w_sub;
    logic                w_ge;
    logic [17:0]         w_diff;
    logic [DIV_BITS-1:0] w_dividend;
    logic [31:0]         w_diff32;
    logic [31:0]         w_pos_prod;
    t_out_item           w_item;

    assign o_pop       = w_start || w_pixel;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        w_lg = (i_cfg.texture_height_log2 > 4'(MAX_TEXTURE_LOG2)) ?
               4'(MAX_TEXTURE_LOG2) : i_cfg.texture_height_log2;
        w_hmask    = 16'((17'd1 << w_lg) - 17'd1);
        w_out_free = !r_out_valid || i_out_ready;
        w_is_start = (i_q_cmd.operation == OP_START);
        w_start    = (r_state == ST_RUN) && i_q_valid && w_is_start;
        w_pixel    = (r_state == ST_RUN) && i_q_valid && !w_is_start && w_out_free;
        w_emit     = w_pixel && (r_cur < r_stop);

        w_trial = {r_rem, r_quot[DIV_BITS-1]};
        w_ge    = (w_trial >= {1'b0, r_divisor});
        w_sub   = w_trial - {1'b0, r_divisor};

        w_diff = 18'(i_q_cmd.first_row) + 18'(i_q_cmd.slice_height[15:1])
               - 18'(i_cfg.screen_height[11:1]);
        w_dividend = DIV_BITS'(1) << ({1'b0, w_lg} + 5'd16);
        w_diff32   = {{14{r_diff[17]}}, r_diff};
        w_pos_prod = w_diff32 * 32'(r_quot);

        w_item.pixel_column   = r_col;
        w_item.pixel_row      = r_cur[11:0] & COORD_MASK;
        w_item.texture_select = r_face;
        w_item.texel_x        = r_tx;
        w_item.texel_y        = 10'(r_pos[31:16] & w_hmask);
        w_item.last_row       = ((r_cur + 13'd1) == r_stop);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (w_start) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_step      <= '0;
            r_pos       <= '0;
            r_cur       <= '0;
            r_stop      <= '0;
            r_col       <= '0;
            r_face      <= '0;
            r_tx        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_cur  <= 13'(i_q_cmd.first_row);
                r_stop <= i_q_cmd.end_row_in;
                r_col  <= i_q_cmd.screen_column & COORD_MASK;
                r_face <= i_q_cmd.wall_face;
                r_tx   <= i_q_cmd.texel_x;
            end else if (w_emit) begin
                r_cur <= r_cur + 13'd1;
                r_pos <= r_pos + r_step;
            end else if (r_state == ST_MUL) begin
                r_step <= 32'(r_quot);
                r_pos  <= w_pos_prod;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_diff    <= w_diff;
            r_rem     <= '0;
            r_quot    <= w_dividend;
            r_divisor <= (i_q_cmd.slice_height == '0) ? 16'd1 : i_q_cmd.slice_height;
            r_cnt     <= DIV_CNT_BITS'(DIV_BITS - 1);
        end else if (r_state == ST_DIV) begin
            r_rem  <= w_ge ? w_sub[15:0] : w_trial[15:0];
            r_quot <= {r_quot[DIV_BITS-2:0], w_ge};
            r_cnt  <= r_cnt - 1'b1;
        end
        if (w_emit) begin
            r_out_item <= w_item;
        end
    end

`ifndef SYNTH
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> !o_pop)
        else $error("command taken during column setup");
    a_mul_to_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |=> (r_state == ST_RUN) && (r_step != '0))
        else $error("column setup did not finish with a nonzero step");
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_emit)
        else $error("pixel issued over a pending output");
`endif

endmodule

// ----- hw/rtl/raycast_wall_texture_column_unit.sv -----
// Raycast wall texture column unit: configuration registers, front, queue and back.
// Path: a pixel transaction passes the front register, a queue entry and the back output register.
// Rate: one pixel transaction per cycle while the output is ready; a column start holds
// the back stage while the bit-serial divider runs (ST_DIV) and then in ST_MUL.
// Reset (synchronous, active low): empty queue, no pending output, step, position and
// rows cleared so pixel transactions give nothing until a column start.
`timescale 1ns / 1ps

module raycast_wall_texture_column_unit import rwtc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    t_cfg r_cfg;
    logic w_q_full;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_pop;
    logic w_q_valid;
    t_cmd w_q_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.texture_width       <= 11'd64;
            r_cfg.texture_height_log2 <= 4'd6;
            r_cfg.screen_height       <= 12'd480;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TEXTURE_WIDTH:       r_cfg.texture_width       <= i_cfg_data[10:0];
                CFG_TEXTURE_HEIGHT_LOG2: r_cfg.texture_height_log2 <= i_cfg_data[3:0];
                CFG_SCREEN_HEIGHT:       r_cfg.screen_height       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rwtc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_cfg      (r_cfg),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    rwtc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    rwtc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
